/* sv/imap_pkg.sv */
// Package with the item types, breakpoint type and codes of the interval map block.
package imap_pkg;

	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 16;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                  op;
		logic [KEY_BITS-1:0]   range_begin;
		logic [KEY_BITS-1:0]   range_end;
		logic [VALUE_BITS-1:0] new_value;
		logic [KEY_BITS-1:0]   query_key;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] found_value;
		logic [1:0]            status;
	} out_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] val;
	} entry_t;

endpackage

/* sv/interval_map_assign_lookup.sv */
// Interval map top level: breakpoint table with range assign and point lookup.
// One sequencer walks the stored table in order, one entry at a time, through a registered memory read.
// An assign streams the merged table into the spare bank and swaps banks when it fits.
// A new item is taken only in the idle state, after the previous result has been handed over.
// Reset clears the breakpoint count, bank select and default value; entries need no clearing.
module interval_map_assign_lookup #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  imap_pkg::in_item_t         in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output imap_pkg::out_item_t        out_item,
	input  logic                       cfg_wr_en,
	input  logic [imap_pkg::VALUE_BITS-1:0] cfg_wr_data
);
	import imap_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = $clog2(TABLE_DEPTH + 3);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ASSIGN = 2'd1;
	localparam logic [1:0] S_LOOKUP = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	logic [1:0]            state_q;
	logic                  bank_q;
	logic [CW-1:0]         count_q;
	logic [VALUE_BITS-1:0] default_value_q;
	in_item_t              req_q;
	logic [CW-1:0]         idx_q;
	logic                  b_done_q;
	logic                  e_done_q;
	logic [VALUE_BITS-1:0] last_q;
	logic [VALUE_BITS-1:0] run_q;
	logic [KW-1:0]         kept_q;
	out_item_t             res_q;
	logic                  out_valid_q;
	out_item_t             out_item_q;
	entry_t                rd_q;

	entry_t                mem [0:1][0:TABLE_DEPTH-1];

	logic                  have;
	logic                  adv;
	logic                  emit;
	entry_t                emit_ent;
	logic                  set_b;
	logic                  set_e;
	logic                  fin;
	logic                  wr_en;
	logic [CW-1:0]         idx_next;
	logic [IW-1:0]         rd_idx;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign have      = (idx_q < count_q);

	always_comb begin
		adv      = 1'b0;
		emit     = 1'b0;
		emit_ent = rd_q;
		set_b    = 1'b0;
		set_e    = 1'b0;
		fin      = 1'b0;
		if (state_q == S_ASSIGN) begin
			priority if (have && rd_q.key < req_q.range_begin) begin
				emit = 1'b1;
				adv  = 1'b1;
			end else if (!b_done_q) begin
				emit     = 1'b1;
				emit_ent = '{key: req_q.range_begin, val: req_q.new_value};
				set_b    = 1'b1;
			end else if (have && rd_q.key < req_q.range_end) begin
				adv = 1'b1;
			end else if (!e_done_q) begin
				set_e    = 1'b1;
				emit     = !(have && rd_q.key == req_q.range_end);
				emit_ent = '{key: req_q.range_end, val: last_q};
			end else if (have) begin
				emit = 1'b1;
				adv  = 1'b1;
			end else begin
				fin = 1'b1;
			end
		end else if (state_q == S_LOOKUP) begin
			if (have && rd_q.key <= req_q.query_key) begin
				adv = 1'b1;
			end else begin
				fin = 1'b1;
			end
		end
	end

	assign idx_next = idx_q + CW'(adv);
	assign rd_idx   = (state_q == S_IDLE) ? '0 : idx_next[IW-1:0];
	assign wr_en    = emit && (emit_ent.val != run_q) && (kept_q < KW'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		rd_q <= mem[bank_q][rd_idx];
		if (wr_en) begin
			mem[~bank_q][kept_q[IW-1:0]] <= emit_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			bank_q          <= 1'b0;
			count_q         <= '0;
			default_value_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				default_value_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_item.op == OP_LOOKUP) begin
							state_q <= S_LOOKUP;
						end else if (in_item.range_begin >= in_item.range_end) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_ASSIGN;
						end
					end
				end
				S_ASSIGN: begin
					if (fin) begin
						state_q <= S_RESULT;
						if (kept_q <= KW'(TABLE_DEPTH)) begin
							bank_q  <= ~bank_q;
							count_q <= kept_q[CW-1:0];
						end
					end
				end
				S_LOOKUP: begin
					if (fin) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			req_q    <= in_item;
			idx_q    <= '0;
			b_done_q <= 1'b0;
			e_done_q <= 1'b0;
			last_q   <= default_value_q;
			run_q    <= default_value_q;
			kept_q   <= '0;
			res_q    <= '{found_value: '0,
				status: (in_item.op == OP_LOOKUP) ? ST_DONE : ST_EMPTY};
		end else begin
			idx_q <= idx_next;
			if (adv) begin
				last_q <= rd_q.val;
			end
			if (set_b) begin
				b_done_q <= 1'b1;
			end
			if (set_e) begin
				e_done_q <= 1'b1;
			end
			if (emit && emit_ent.val != run_q) begin
				kept_q <= kept_q + KW'(1);
				run_q  <= emit_ent.val;
			end
			if (fin && state_q == S_ASSIGN) begin
				res_q.status <= (kept_q <= KW'(TABLE_DEPTH)) ? ST_DONE : ST_FULL;
			end
			if (fin && state_q == S_LOOKUP) begin
				res_q.found_value <= last_q;
			end
		end
		if (state_q == S_RESULT && (!out_valid_q || out_ready)) begin
			out_item_q <= res_q;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("breakpoint count exceeds table depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASSIGN || state_q == S_LOOKUP) |-> idx_q <= count_q)
		else $error("scan index ran past the stored breakpoints");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ASSIGN |-> kept_q <= KW'(count_q) + KW'(2))
		else $error("assign produced more than two extra breakpoints");

	a_bank_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOKUP || state_q == S_ASSIGN)
			|=> $stable(bank_q) || state_q == S_RESULT)
		else $error("bank swapped in the middle of a table walk");

	a_result_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && req_q.op == OP_LOOKUP) |-> res_q.status == ST_DONE)
		else $error("lookup carries a non-zero status");
`endif

endmodule

/* tb/interval_map_assign_lookup_test.sv */
// Self-checking testbench of the interval map block: directed cases, then random traffic.
`timescale 1ns / 100ps

module interval_map_assign_lookup_test;
	import imap_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_GAP = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_wr_en = 1'b0;
	logic [VALUE_BITS-1:0] cfg_wr_data = '0;

	bit [KEY_BITS-1:0] bp_key [TABLE_DEPTH];
	bit [VALUE_BITS-1:0] bp_val [TABLE_DEPTH];
	int unsigned bp_count = 0;
	bit [VALUE_BITS-1:0] dflt_value = '0;

	out_item_t pending_results [$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	interval_map_assign_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic bit [VALUE_BITS-1:0] map_value(bit [KEY_BITS-1:0] key);
		bit [VALUE_BITS-1:0] v;
		v = dflt_value;
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] > key)
				break;
			v = bp_val[i];
		end
		return v;
	endfunction

	function automatic logic [1:0] assign_range(bit [KEY_BITS-1:0] lo, bit [KEY_BITS-1:0] hi,
			bit [VALUE_BITS-1:0] val);
		bit [KEY_BITS-1:0] nk [TABLE_DEPTH+2];
		bit [VALUE_BITS-1:0] nv [TABLE_DEPTH+2];
		bit [VALUE_BITS-1:0] end_val;
		bit [VALUE_BITS-1:0] run;
		bit end_present;
		int n;
		int kept;
		n = 0;
		kept = 0;
		end_present = 1'b0;
		if (lo >= hi)
			return ST_EMPTY;
		end_val = map_value(hi);
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] < lo) begin
				nk[n] = bp_key[i];
				nv[n] = bp_val[i];
				n++;
			end
			if (bp_key[i] == hi)
				end_present = 1'b1;
		end
		nk[n] = lo;
		nv[n] = val;
		n++;
		if (!end_present) begin
			nk[n] = hi;
			nv[n] = end_val;
			n++;
		end
		// The tail is checked for overflow before merging, so a full table rejects early.
		for (int i = 0; i < bp_count; i++) begin
			if (bp_key[i] >= hi) begin
				if (n >= TABLE_DEPTH + 2)
					return ST_FULL;
				nk[n] = bp_key[i];
				nv[n] = bp_val[i];
				n++;
			end
		end
		run = dflt_value;
		for (int i = 0; i < n; i++) begin
			if (nv[i] != run) begin
				nk[kept] = nk[i];
				nv[kept] = nv[i];
				kept++;
				run = nv[i];
			end
		end
		if (kept > TABLE_DEPTH)
			return ST_FULL;
		for (int i = 0; i < kept; i++) begin
			bp_key[i] = nk[i];
			bp_val[i] = nv[i];
		end
		bp_count = kept;
		return ST_DONE;
	endfunction

	function automatic out_item_t predict_item(in_item_t it);
		out_item_t r;
		if (it.op == OP_LOOKUP) begin
			r.found_value = map_value(it.query_key);
			r.status = ST_DONE;
		end else begin
			r.found_value = '0;
			r.status = assign_range(it.range_begin, it.range_end, it.new_value);
		end
		return r;
	endfunction

	function automatic in_item_t make_assign(bit [KEY_BITS-1:0] lo, bit [KEY_BITS-1:0] hi,
			bit [VALUE_BITS-1:0] val);
		in_item_t it;
		it.op = OP_ASSIGN;
		it.range_begin = lo;
		it.range_end = hi;
		it.new_value = val;
		it.query_key = KEY_BITS'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_lookup(bit [KEY_BITS-1:0] key);
		in_item_t it;
		it.op = OP_LOOKUP;
		it.range_begin = KEY_BITS'($urandom);
		it.range_end = KEY_BITS'($urandom);
		it.new_value = VALUE_BITS'($urandom);
		it.query_key = key;
		return it;
	endfunction

	function automatic in_item_t random_item();
		int pick;
		int span;
		bit [KEY_BITS-1:0] a;
		bit [KEY_BITS-1:0] b;
		bit [VALUE_BITS-1:0] val;
		pick = $urandom_range(99);
		span = (pick < 70) ? 63 : (pick < 90) ? 4095 : 65535;
		a = KEY_BITS'($urandom_range(span));
		b = KEY_BITS'($urandom_range(span));
		case ($urandom_range(5))
			0: val = dflt_value;
			1: val = 16'd1;
			2: val = 16'd2;
			3: val = 16'hFFFF;
			default: val = VALUE_BITS'($urandom);
		endcase
		if ($urandom_range(99) < 45) begin
			if (bp_count > 0 && $urandom_range(1))
				a = KEY_BITS'(bp_key[$urandom_range(bp_count - 1)] + $urandom_range(2) - 1);
			return make_lookup(a);
		end
		pick = $urandom_range(99);
		if (pick < 5)
			return make_assign('0, 16'hFFFF, dflt_value);
		if (pick < 12)
			return make_assign((a > b) ? a : b, (a > b) ? b : a, val);
		return make_assign((a < b) ? a : b, (a < b) ? b : a, val);
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_item(it));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default(bit [VALUE_BITS-1:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dflt_value = v;
	endtask

	task automatic test_empty_table();
		send_item(make_lookup('0));
		send_item(make_lookup(16'hFFFF));
		send_item(make_assign(16'd5, 16'd5, 16'h1234));
		send_item(make_assign(16'hFFFF, '0, 16'h4321));
	endtask

	task automatic test_interval_assign();
		send_item(make_assign('0, 16'hFFFF, 16'hFFFF));
		send_item(make_lookup('0));
		send_item(make_lookup(16'hFFFE));
		send_item(make_lookup(16'hFFFF));
		send_item(make_assign(16'd100, 16'd200, '0));
		send_item(make_lookup(16'd150));
		send_item(make_assign('0, 16'hFFFF, '0));
		send_item(make_lookup(16'd100));
	endtask

	task automatic test_table_full();
		for (int i = 0; i < TABLE_DEPTH / 2 + 1; i++)
			send_item(make_assign(KEY_BITS'(2 * i), KEY_BITS'(2 * i + 1), VALUE_BITS'(i + 1)));
		send_item(make_assign('0, 16'd16, dflt_value));
	endtask

	task automatic test_default_value();
		write_default(16'hFFFF);
		send_item(make_lookup(16'h1234));
		send_item(make_assign(16'd10, 16'd20, 16'hFFFF));
		write_default('0);
		send_item(make_lookup(16'd15));
	endtask

	task automatic test_random_traffic(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_results();
			send_item(random_item());
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: found_value %h status %0d",
					out_item.found_value, out_item.status);
				mismatches++;
			end else begin
				out_item_t exp_item;
				exp_item = pending_results.pop_front();
				if (out_item.found_value !== exp_item.found_value) begin
					$error("found_value: expected %h, got %h",
						exp_item.found_value, out_item.found_value);
					mismatches++;
				end
				if (out_item.status !== exp_item.status) begin
					$error("status: expected %0d, got %0d", exp_item.status, out_item.status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("interval_map_assign_lookup regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_interval_assign();
		test_table_full();
		test_default_value();
		test_random_traffic(150, 0, 0);
		write_default(16'hFFFF);
		test_random_traffic(150, 85, 0);
		write_default(VALUE_BITS'($urandom));
		test_random_traffic(150, 0, 85);
		write_default('0);
		test_random_traffic(150, 20, 20);
		drain_results();
		if (mismatches == 0)
			$display("interval_map_assign_lookup regression: pass");
		else
			$display("interval_map_assign_lookup regression: fail");
		$finish;
	end

endmodule
